/* hdl/tre_pkg.sv */
// Shared types, constants and tier tables for the tiered residual encoder.
`timescale 1ns / 1ps
package tre_pkg;

  localparam int RESID_W   = 64;  // residual and zigzag width
  localparam int NBITS_W   = 7;   // significant bit count, 0..64
  localparam int K_W       = 5;   // base payload width register
  localparam int TIER_W    = 3;
  localparam int PEND_W    = 7;   // pending bits held between items
  localparam int PCNT_W    = 3;   // pending bit count, 0..7
  localparam int CODE_W    = 68;  // longest code: 4-bit prefix + 64 raw bits
  localparam int WORD_W    = 75;  // pending bits + code
  localparam int FRAME_W   = 80;  // word left-aligned on a whole-byte window
  localparam int BYTE_W    = 8;
  localparam int SER_W     = 72;  // up to nine bytes per item
  localparam int NB_W      = 4;   // byte count per item, 0..9

  localparam logic [K_W-1:0]    K_RESET    = 5'd3;
  localparam logic              MODE_ENC   = 1'b0;
  localparam logic              MODE_FLUSH = 1'b1;
  localparam logic [TIER_W-1:0] TIER_RAW   = 3'd4;

  // Classified item handed from the classify stage to the packer.
  typedef struct packed {
    logic                  mode;
    logic [RESID_W-1:0]    zz;
    logic [RESID_W-1:0]    raw;
    logic [TIER_W-1:0]     tier;
  } tre_class_t;

  // Bytes of one item, first byte in the top bits, plus how many are valid.
  typedef struct packed {
    logic [SER_W-1:0]      bytes;
    logic [NB_W-1:0]       nbytes;
  } tre_frame_t;

  function automatic logic [3:0] prefix_code(input logic [TIER_W-1:0] tier);
    case (tier)
      3'd0:    return 4'd0;
      3'd1:    return 4'd2;
      3'd2:    return 4'd6;
      3'd3:    return 4'd14;
      default: return 4'd15;
    endcase
  endfunction

  function automatic logic [2:0] prefix_len(input logic [TIER_W-1:0] tier);
    case (tier)
      3'd0:    return 3'd1;
      3'd1:    return 3'd2;
      3'd2:    return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [3:0] payload_extra(input logic [TIER_W-1:0] tier);
    case (tier)
      3'd0:    return 4'd0;
      3'd1:    return 4'd2;
      3'd2:    return 4'd5;
      3'd3:    return 4'd10;
      default: return 4'd0;
    endcase
  endfunction

endpackage

/* hdl/tre_classify.sv */
// Input register, zigzag mapping, significant bit count and tier selection.
`timescale 1ns / 1ps
module tre_classify import tre_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [K_W-1:0]     k,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [RESID_W-1:0] in_residual,
  output logic               item_valid,
  input  logic               item_ready,
  output tre_class_t         item
);

  function automatic logic [NBITS_W-1:0] sig_bits(input logic [RESID_W-1:0] v);
    logic [3:0]         lane_pos [8];
    logic [NBITS_W-1:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      lane_pos[b] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        if (v[b*8+i]) lane_pos[b] = 4'(i + 1);
      end
    end
    for (int b = 0; b < 8; b++) begin
      if (lane_pos[b] != 4'd0) n = 7'(b * 8) + 7'(lane_pos[b]);
    end
    return n;
  endfunction

  logic               s0_valid_r;
  logic               s0_mode_r;
  logic [RESID_W-1:0] s0_res_r;
  logic               s1_valid_r;
  tre_class_t         s1_item_r;
  tre_class_t         s1_item_nxt;
  logic               s0_ready;
  logic               s1_ready;
  logic [NBITS_W-1:0] nbits;
  logic [NBITS_W-1:0] k7;

  assign s1_ready = !s1_valid_r || item_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ready = s0_ready;

  always_comb begin
    k7                = {2'b00, k};
    s1_item_nxt.mode  = s0_mode_r;
    s1_item_nxt.raw   = s0_res_r;
    s1_item_nxt.zz    = {s0_res_r[RESID_W-2:0], 1'b0} ^ {RESID_W{s0_res_r[RESID_W-1]}};
    nbits             = sig_bits(s1_item_nxt.zz);
    s1_item_nxt.tier  = 3'(nbits > k7) + 3'(nbits > k7 + 7'd2)
                      + 3'(nbits > k7 + 7'd5) + 3'(nbits > k7 + 7'd10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_r <= in_valid;
      if (s1_ready) s1_valid_r <= s0_valid_r;
    end
    if (s0_ready && in_valid) begin
      s0_mode_r <= in_mode;
      s0_res_r  <= in_residual;
    end
    if (s1_ready && s0_valid_r) s1_item_r <= s1_item_nxt;
  end

  assign item_valid = s1_valid_r;
  assign item       = s1_item_r;

endmodule

/* hdl/tre_pack.sv */
// Code assembly: prefix and payload appended to the pending bits, split into bytes.
`timescale 1ns / 1ps
module tre_pack import tre_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [K_W-1:0] k,
  input  tre_class_t     item,
  input  logic           load,
  output tre_frame_t     frame
);

  logic [PEND_W-1:0]  pbits_r, pbits_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [NBITS_W-1:0] plen;
  logic [NBITS_W-1:0] code_len;
  logic [NBITS_W-1:0] total;
  logic [NBITS_W-1:0] shamt;
  logic [CODE_W-1:0]  code;
  logic [RESID_W-1:0] payload;
  logic [WORD_W-1:0]  word;
  logic [FRAME_W-1:0] frame_bits;
  logic [BYTE_W-1:0]  pmask;

  always_comb begin
    plen     = (item.tier == TIER_RAW) ? 7'd64
             : 7'({2'b00, k}) + 7'(payload_extra(item.tier));
    payload  = (item.tier == TIER_RAW) ? item.raw : item.zz;
    if (item.mode == MODE_FLUSH) begin
      // Pad the partial byte with zeros up to the byte boundary
      code     = '0;
      code_len = (pcnt_r == '0) ? 7'd0 : 7'(4'd8 - {1'b0, pcnt_r});
    end else begin
      code     = (68'(prefix_code(item.tier)) << plen) | 68'(payload);
      code_len = plen + 7'(prefix_len(item.tier));
    end
    total      = 7'(pcnt_r) + code_len;
    word       = (75'(pbits_r) << code_len) | 75'(code);
    shamt      = 7'd80 - total;
    frame_bits = 80'(word) << shamt;
    frame.bytes  = frame_bits[FRAME_W-1:FRAME_W-SER_W];
    frame.nbytes = total[NBITS_W-1:3];
    pcnt_nxt   = total[2:0];
    pmask      = (8'd1 << total[2:0]) - 8'd1;
    pbits_nxt  = word[PEND_W-1:0] & pmask[PEND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r <= '0;
      pcnt_r  <= '0;
    end else if (load) begin
      pbits_r <= pbits_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

/* hdl/tre_serialize.sv */
// Byte output register: shifts out one item's bytes, one per cycle while out_ready is high.
`timescale 1ns / 1ps
module tre_serialize import tre_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tre_frame_t        frame,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [SER_W-1:0] buf_r;
  logic [NB_W-1:0]  cnt_r;
  logic             take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && out_ready;
  assign free      = (cnt_r == '0) || (cnt_r == 4'd1 && out_ready);
  assign out_byte  = buf_r[SER_W-1:SER_W-BYTE_W];
  assign out_last  = (cnt_r == 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= frame.nbytes;
    end else if (take) begin
      cnt_r <= cnt_r - 4'd1;
    end
    if (load) begin
      buf_r <= frame.bytes;
    end else if (take) begin
      buf_r <= {buf_r[SER_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

endmodule

/* hdl/tiered_residual_encoder_top.sv */
// Top level of the tiered residual encoder: zigzag, tier code and byte packing.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in_     | slave     | in_tvalid / in_tready      | tdata: residual; tuser: mode
//  out_    | master    | out_tvalid / out_tready    | tdata: out_byte; tlast: last
//  cfg_    | slave     | cfg_valid / cfg_ready      | cfg_data: payload_base_bits
//
// An item is taken into the input register, classified into the item register
// and packed into the byte output register, which sends one byte per cycle
// while out_tready is high; an item makes 0 to 9 bytes (nine for a raw tier
// item on seven pending bits). Items that make no byte pass at one per cycle
// while the byte output register is free. Reset (rst_n low, synchronous)
// empties the pipeline, clears the pending bits and sets the base width to 3.
// A stall on out_ holds the bytes and backs up through the stages to in_tready.
`timescale 1ns / 1ps
module tiered_residual_encoder_top import tre_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [RESID_W-1:0] in_tdata,   // [63:0] residual
  input  logic               in_tuser,   // [0] mode
  // result items
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BYTE_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic               out_tlast,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [K_W-1:0]     cfg_data    // [4:0] payload_base_bits
);

  logic [K_W-1:0] k_r;
  logic           item_valid;
  logic           ser_free;
  logic           load;
  tre_class_t     item;
  tre_frame_t     frame;

  // Base width register; the user must write it only while the block is idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_r <= cfg_data;
    end
  end

  // Hand a classified item to the packer once the byte register can take it
  assign load = item_valid && ser_free;

  tre_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .k           (k_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_residual (in_tdata),
    .item_valid  (item_valid),
    .item_ready  (ser_free),
    .item        (item)
  );

  tre_pack u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .k     (k_r),
    .item  (item),
    .load  (load),
    .frame (frame)
  );

  tre_serialize u_serialize (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .frame     (frame),
    .free      (ser_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

/* tb/tiered_residual_encoder_top_tb.sv */
// Self-checking testbench for the tiered residual encoder: directed and random residual streams.
`timescale 1ns / 1ps
module tiered_residual_encoder_top_tb;
  import tre_pkg::*;

  // Cycles of silence after the last byte before a width change is safe; an item
  // that yields no byte may still be crossing the three pipeline stages.
  localparam int SETTLE_CYCLES = 8;
  // Cycles to keep watching for stray bytes once the stream has drained.
  localparam int DRAIN_CYCLES  = 20;
  // Time limit well above the slowest correct run (147 items, nine bytes each,
  // long sink stalls).
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // One expected byte of the packed stream.
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } stream_byte_t;

  // One pending entry for the driver: either a residual/flush item or a width change.
  typedef struct packed {
    logic               is_cfg;
    logic [K_W-1:0]     width;
    logic               mode;
    logic [RESID_W-1:0] residual;
  } send_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [RESID_W-1:0] in_tdata = '0;
  logic               in_tuser = MODE_ENC;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BYTE_W-1:0]  out_tdata;
  logic               out_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [K_W-1:0]     cfg_data = '0;

  tiered_residual_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder prediction: its own copy of the pending bits and the base width.
  // ---------------------------------------------------------------------------
  logic [PEND_W-1:0] held_bits  = '0;
  logic [PCNT_W-1:0] held_count = '0;
  logic [K_W-1:0]    base_width = K_RESET;

  stream_byte_t bytes_due[$];
  int           errors = 0;

  // Shift n bits of v into the pending bits, MSB first; emit each full byte.
  function automatic void pack_bits(input logic [RESID_W-1:0] v, input int n);
    logic [BYTE_W-1:0] acc;
    stream_byte_t      b;
    for (int i = n; i > 0; i--) begin
      acc = {held_bits, v[i-1]};
      if (held_count == 3'd7) begin
        b.last = 1'b0;
        b.data = acc;
        bytes_due.push_back(b);
        held_bits  = '0;
        held_count = '0;
      end else begin
        held_bits  = acc[PEND_W-1:0];
        held_count = held_count + 3'd1;
      end
    end
  endfunction

  // Work out every byte that one accepted item must produce.
  function automatic void predict_item(input logic mode, input logic [RESID_W-1:0] res);
    logic [RESID_W-1:0] zz;
    int                 nsig;
    int                 k;
    int                 tier;
    int                 first_new;
    stream_byte_t       b;
    first_new = bytes_due.size();
    if (mode == MODE_FLUSH) begin
      // pad the partial byte with zeros; nothing pending means nothing to send
      if (held_count != 0) begin
        b.last = 1'b0;
        b.data = {held_bits, 1'b0} << (7 - held_count);
        bytes_due.push_back(b);
        held_bits  = '0;
        held_count = '0;
      end
    end else begin
      k    = base_width;
      zz   = {res[RESID_W-2:0], 1'b0} ^ {RESID_W{res[RESID_W-1]}};
      nsig = 0;
      for (int i = 0; i < RESID_W; i++)
        if (zz[i]) nsig = i + 1;
      tier = (nsig > k) + (nsig > k + 2) + (nsig > k + 5) + (nsig > k + 10);
      case (tier)
        0: begin
          pack_bits(64'b0, 1);
          pack_bits(zz, k);
        end
        1: begin
          pack_bits(64'b10, 2);
          pack_bits(zz, k + 2);
        end
        2: begin
          pack_bits(64'b110, 3);
          pack_bits(zz, k + 5);
        end
        3: begin
          pack_bits(64'b1110, 4);
          pack_bits(zz, k + 10);
        end
        default: begin
          // raw tier: the residual as it stands, high half first
          pack_bits(64'b1111, 4);
          pack_bits({32'b0, res[63:32]}, 32);
          pack_bits({32'b0, res[31:0]}, 32);
        end
      endcase
    end
    if (bytes_due.size() > first_new)
      bytes_due[bytes_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  send_entry_t send_q[$];

  // Residual whose zigzag value has exactly n significant bits, other bits random.
  function automatic logic [RESID_W-1:0] resid_of_width(input int n);
    logic [RESID_W-1:0] zz;
    logic [RESID_W-1:0] mask;
    if (n <= 0) return '0;
    if (n > RESID_W) n = RESID_W;
    mask = (n == RESID_W) ? '1 : ((64'd1 << n) - 64'd1);
    zz   = ({$urandom, $urandom} & mask) | (64'd1 << (n - 1));
    return zz[0] ? ~(zz >> 1) : (zz >> 1);
  endfunction

  task automatic add_encode(input logic [RESID_W-1:0] res);
    send_entry_t e;
    e.is_cfg   = 1'b0;
    e.width    = '0;
    e.mode     = MODE_ENC;
    e.residual = res;
    send_q.push_back(e);
  endtask

  // The residual field rides along with random content and must be ignored.
  task automatic add_flush();
    send_entry_t e;
    e.is_cfg   = 1'b0;
    e.width    = '0;
    e.mode     = MODE_FLUSH;
    e.residual = {$urandom, $urandom};
    send_q.push_back(e);
  endtask

  task automatic add_width(input logic [K_W-1:0] w);
    send_entry_t e;
    e.is_cfg   = 1'b1;
    e.width    = w;
    e.mode     = MODE_ENC;
    e.residual = '0;
    send_q.push_back(e);
  endtask

  // Random item, biased towards the tier boundaries of the current width.
  task automatic add_random_item(input int k);
    int pick;
    int offset;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      add_flush();
    end else if (pick < 60) begin
      case ($urandom_range(0, 7))
        0: offset = 0;
        1: offset = 1;
        2: offset = 2;
        3: offset = 3;
        4: offset = 5;
        5: offset = 6;
        6: offset = 10;
        default: offset = 11;
      endcase
      add_encode(resid_of_width(k + offset));
    end else if (pick < 92) begin
      add_encode(resid_of_width($urandom_range(0, RESID_W)));
    end else begin
      add_encode({$urandom, $urandom});
    end
  endtask

  initial begin
    int phase_width[5];
    // Directed part at the reset width of 3: tier limits sit at 3, 5, 8 and 13 bits.
    add_encode(64'd0);
    add_encode(resid_of_width(3));
    add_encode(resid_of_width(4));
    add_encode(resid_of_width(5));
    add_encode(resid_of_width(6));
    add_encode(resid_of_width(8));
    add_encode(resid_of_width(9));
    add_encode(resid_of_width(13));
    add_encode(resid_of_width(14));
    add_encode(64'h7FFF_FFFF_FFFF_FFFF);
    add_encode(64'h8000_0000_0000_0000);
    add_encode(64'hFFFF_FFFF_FFFF_FFFF);
    add_encode(64'd1);
    add_flush();
    add_flush();                          // nothing left to pad
    add_encode(64'd0);                    // four bits only, no byte yet
    add_encode(64'd0);
    add_flush();
    // Leave seven bits pending, then a raw item: nine bytes from one item.
    add_encode(64'd0);
    add_encode(resid_of_width(7));
    add_encode(64'h5555_AAAA_0F0F_F0F0);
    add_flush();

    // Random phases, each behind a width change; both extremes included.
    phase_width[0] = 0;
    phase_width[1] = 31;
    phase_width[2] = $urandom_range(1, 30);
    phase_width[3] = 1;
    phase_width[4] = $urandom_range(0, 31);
    for (int p = 0; p < 5; p++) begin
      add_width(phase_width[p][K_W-1:0]);
      for (int i = 0; i < 25; i++)
        add_random_item(phase_width[p]);
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones, and calm runs with none.
  // ---------------------------------------------------------------------------
  int src_calm  = 0;
  int sink_calm = 0;

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake bookkeeping, sampled at the rising edge
  // ---------------------------------------------------------------------------
  logic in_acc  = 1'b0;   // the item on in_ was taken at the last rising edge
  logic cfg_acc = 1'b0;   // the width write was taken at the last rising edge
  int   quiet   = 0;      // cycles without traffic and with nothing owed

  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready)
        base_width = cfg_data;
      if (out_tvalid && out_tready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected byte 0x%02h (last %0b)", out_tdata, out_tlast);
          errors++;
        end else begin
          want = bytes_due.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || bytes_due.size() != 0)
        quiet = 0;
      else if (quiet < 1000)
        quiet++;
    end
    in_acc  <= rst_n && in_tvalid && in_tready;
    cfg_acc <= rst_n && cfg_valid && cfg_ready;
  end

  // ---------------------------------------------------------------------------
  // Driver: advance on the falling edge, hold an offer until it is taken.
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(negedge clk) begin
    logic        next_in;
    logic        next_cfg;
    send_entry_t e;
    if (rst_n && !((in_tvalid && !in_acc) || (cfg_valid && !cfg_acc))) begin
      next_in  = 1'b0;
      next_cfg = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (send_q.size() != 0) begin
        if (send_q[0].is_cfg) begin
          // change width only once the stream is drained and the pipeline settled
          if (bytes_due.size() == 0 && quiet >= SETTLE_CYCLES) begin
            e = send_q.pop_front();
            cfg_data <= e.width;
            next_cfg = 1'b1;
          end
        end else begin
          e = send_q.pop_front();
          in_tdata <= e.residual;
          in_tuser <= e.mode;
          next_in  = 1'b1;
          src_gap  = pick_gap(src_calm);
        end
      end
      in_tvalid <= next_in;
      cfg_valid <= next_cfg;
    end
  end

  // Sink: stall out_ at random, with calm runs of steady acceptance.
  int sink_stall = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        sink_stall = pick_gap(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (send_q.size() != 0 || in_tvalid || cfg_valid)
      @(posedge clk);
    while (bytes_due.size() != 0)
      @(posedge clk);
    // keep watching for bytes nobody asked for
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tiered_residual_encoder_top_tb passed");
    end else begin
      $display("tiered_residual_encoder_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tiered_residual_encoder_top_tb failed");
    $finish;
  end

endmodule
